/* rtl/core/bpcr_pkg.sv */
package bpcr_pkg;

    localparam int CH_W       = 2;
    localparam int SMP_W      = 12;
    localparam int GAIN_W     = 16;
    localparam int THR_W      = 12;
    localparam int POT_W      = 8;
    localparam int ADJ_W      = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd660;
    localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 16'd13200;
    localparam logic [THR_W-1:0]  LOW_THR_RST    = 12'd149;
    localparam logic [POT_W-1:0]  POT_MAX        = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN     = 2'd0,
        CFG_DERIV_GAIN    = 2'd1,
        CFG_LOW_THRESHOLD = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic            valid;
        logic [CH_W-1:0] ch;
        logic            present;
        logic            active;
    } t_item_ctl;

    typedef struct packed {
        logic [GAIN_W-1:0] prop;
        logic [GAIN_W-1:0] deriv;
    } t_gains;

    typedef struct packed {
        logic [CH_W-1:0]  ch;
        logic             enable;
        logic [POT_W-1:0] pot;
    } t_result;

endpackage

/* rtl/core/bpcr_filter.sv */
module bpcr_filter #(
    parameter int WINDOW   = 512,
    parameter int CHANNELS = 4
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  bpcr_pkg::t_item_ctl                        i_ctl,
    input  logic [bpcr_pkg::SMP_W-1:0]                 i_sample,
    input  logic [bpcr_pkg::SMP_W-1:0]                 i_level,
    input  bpcr_pkg::t_item_ctl                        i_wb_ctl,
    input  logic [bpcr_pkg::SMP_W+$clog2(WINDOW)-1:0]  i_wb_sum,
    input  logic [bpcr_pkg::SMP_W+$clog2(WINDOW)-1:0]  i_wb_prev,
    input  logic [bpcr_pkg::POT_W-1:0]                 i_wb_pot,
    input  logic [$clog2(WINDOW)-1:0]                  i_wb_pos,
    output logic                                       o_clearing,
    output bpcr_pkg::t_item_ctl                        o_ctl,
    output logic signed [bpcr_pkg::SMP_W+$clog2(WINDOW):0] o_err,
    output logic signed [bpcr_pkg::SMP_W+$clog2(WINDOW):0] o_dsum,
    output logic [bpcr_pkg::SMP_W+$clog2(WINDOW)-1:0]  o_sum,
    output logic [bpcr_pkg::SMP_W+$clog2(WINDOW)-1:0]  o_prev,
    output logic [bpcr_pkg::POT_W-1:0]                 o_pot,
    output logic [$clog2(WINDOW)-1:0]                  o_pos
);

    localparam int PW         = $clog2(WINDOW);
    localparam int SUM_W      = bpcr_pkg::SMP_W + PW;
    localparam int DIFF_W     = SUM_W + 1;
    localparam int CHW        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ST_W       = 2 * SUM_W + bpcr_pkg::POT_W + PW;
    localparam int RAW        = CHW + PW;
    localparam int RING_DEPTH = CHANNELS << PW;
    localparam logic [PW-1:0]    POS_LAST = PW'(WINDOW - 1);
    localparam logic [RAW-1:0]   CLR_LAST = RAW'(RING_DEPTH - 1);
    localparam logic [RAW-1:0]   CH_LIMIT = RAW'(CHANNELS);
    localparam logic [SUM_W-1:0] WIN_LEN  = SUM_W'(WINDOW);

    logic [bpcr_pkg::SMP_W-1:0] ring_mem [RING_DEPTH];
    logic [ST_W-1:0]            st_mem   [CHANNELS];

    logic           r_clearing;
    logic [RAW-1:0] r_clr_addr;

    bpcr_pkg::t_item_ctl        r1_ctl;
    logic [bpcr_pkg::SMP_W-1:0] r1_sample;
    logic [bpcr_pkg::SMP_W-1:0] r1_target;
    logic [ST_W-1:0]            r_st_q;

    bpcr_pkg::t_item_ctl        r2_ctl;
    logic [bpcr_pkg::SMP_W-1:0] r2_sample;
    logic [bpcr_pkg::SMP_W-1:0] r2_target;
    logic [SUM_W-1:0]           r2_sum;
    logic [SUM_W-1:0]           r2_prev;
    logic [bpcr_pkg::POT_W-1:0] r2_pot;
    logic [PW-1:0]              r2_pos;
    logic [bpcr_pkg::SMP_W-1:0] r_ring_q;

    logic [SUM_W-1:0]           st_sum;
    logic [SUM_W-1:0]           st_prev;
    logic [bpcr_pkg::POT_W-1:0] st_pot;
    logic [PW-1:0]              st_pos;

    logic [SUM_W-1:0]          n_sum;
    logic [SUM_W-1:0]          n_prev;
    logic [PW-1:0]             n_pos;
    logic [SUM_W-1:0]          target_scaled;
    logic signed [DIFF_W-1:0]  n_err;
    logic signed [DIFF_W-1:0]  n_dsum;

    assign o_clearing = r_clearing;
    assign {st_sum, st_prev, st_pot, st_pos} = r_st_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == CLR_LAST) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing && (r_clr_addr < CH_LIMIT)) begin
            st_mem[CHW'(r_clr_addr)] <= '0;
        end else if (i_wb_ctl.valid && i_wb_ctl.present) begin
            st_mem[CHW'(i_wb_ctl.ch)] <= {i_wb_sum, i_wb_prev, i_wb_pot, i_wb_pos};
        end
        r_st_q <= st_mem[CHW'(i_ctl.ch)];
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            ring_mem[r_clr_addr] <= '0;
        end else if (r2_ctl.valid && r2_ctl.active) begin
            ring_mem[{CHW'(r2_ctl.ch), r2_pos}] <= r2_sample;
        end
        r_ring_q <= ring_mem[{CHW'(r1_ctl.ch), st_pos}];
    end

    always_comb begin
        target_scaled = SUM_W'(r2_target) * WIN_LEN;
        if (r2_ctl.active) begin
            n_sum = r2_sum - SUM_W'(r_ring_q) + SUM_W'(r2_sample);
            n_prev = n_sum;
        end else begin
            n_sum = r2_sum;
            n_prev = r2_prev;
        end
        n_pos = (r2_pos == POS_LAST) ? '0 : r2_pos + 1'b1;
        n_err = $signed({1'b0, n_sum}) - $signed({1'b0, target_scaled});
        n_dsum = $signed({1'b0, n_sum}) - $signed({1'b0, r2_prev});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
            r2_ctl <= '0;
            o_ctl <= '0;
        end else begin
            r1_ctl <= i_ctl;
            r2_ctl <= r1_ctl;
            o_ctl <= r2_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_sample <= i_sample;
        r1_target <= i_level;
        r2_sample <= r1_sample;
        r2_target <= r1_target;
        r2_sum <= st_sum;
        r2_prev <= st_prev;
        r2_pot <= st_pot;
        r2_pos <= st_pos;
        o_err <= n_err;
        o_dsum <= n_dsum;
        o_sum <= n_sum;
        o_prev <= n_prev;
        o_pot <= r2_pot;
        o_pos <= n_pos;
    end

endmodule

/* rtl/core/bpcr_pd_calc.sv */
module bpcr_pd_calc #(
    parameter int WINDOW         = 512,
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  bpcr_pkg::t_gains                               i_gains,
    input  bpcr_pkg::t_item_ctl                            i_ctl,
    input  logic signed [bpcr_pkg::SMP_W+$clog2(WINDOW):0] i_err,
    input  logic signed [bpcr_pkg::SMP_W+$clog2(WINDOW):0] i_dsum,
    input  logic [bpcr_pkg::SMP_W+$clog2(WINDOW)-1:0]      i_sum,
    input  logic [bpcr_pkg::SMP_W+$clog2(WINDOW)-1:0]      i_prev,
    input  logic [bpcr_pkg::POT_W-1:0]                     i_pot,
    input  logic [$clog2(WINDOW)-1:0]                      i_pos,
    output bpcr_pkg::t_item_ctl                            o_done,
    output logic [bpcr_pkg::SMP_W+$clog2(WINDOW)-1:0]      o_wb_sum,
    output logic [bpcr_pkg::SMP_W+$clog2(WINDOW)-1:0]      o_wb_prev,
    output logic [bpcr_pkg::POT_W-1:0]                     o_wb_pot,
    output logic [$clog2(WINDOW)-1:0]                      o_wb_pos,
    output bpcr_pkg::t_result                              o_result
);

    localparam int PW     = $clog2(WINDOW);
    localparam int SUM_W  = bpcr_pkg::SMP_W + PW;
    localparam int DIFF_W = SUM_W + 1;
    localparam int PROD_W = bpcr_pkg::GAIN_W + 1 + DIFF_W;
    localparam int NUM_W  = PROD_W + 1;
    localparam int MAG_W  = NUM_W - GAIN_FRAC_BITS;
    localparam int MW     = bpcr_pkg::ADJ_W + PW;
    localparam int EXT_W  = MAG_W + MW;
    localparam int K      = MW + PW;
    localparam int RW     = MW + 2;
    localparam int QP_W   = MW + RW;
    localparam int AW     = bpcr_pkg::ADJ_W + 1;
    localparam logic [EXT_W-1:0] LIMIT = EXT_W'(longint'(WINDOW) << bpcr_pkg::ADJ_W);
    localparam logic [RW-1:0]    RECIP =
        RW'(((longint'(1) << K) + longint'(WINDOW) - longint'(1)) / longint'(WINDOW));
    localparam logic [bpcr_pkg::ADJ_W-1:0] Q_CAP = '1;

    logic signed [bpcr_pkg::GAIN_W:0] prop_s;
    logic signed [bpcr_pkg::GAIN_W:0] deriv_s;

    bpcr_pkg::t_item_ctl        r4_ctl, r5_ctl, r6_ctl;
    logic signed [PROD_W-1:0]   r4_pprop;
    logic signed [PROD_W-1:0]   r4_pderiv;
    logic [SUM_W-1:0]           r4_sum, r5_sum, r6_sum;
    logic [SUM_W-1:0]           r4_prev, r5_prev, r6_prev;
    logic [bpcr_pkg::POT_W-1:0] r4_pot, r5_pot, r6_pot;
    logic [PW-1:0]              r4_pos, r5_pos, r6_pos;

    logic signed [NUM_W-1:0] num;
    logic                    n_neg;
    logic [NUM_W-1:0]        num_abs;
    logic [MAG_W-1:0]        mag;
    logic                    n_big;
    logic                    r5_neg, r5_big;
    logic [MW-1:0]           r5_m;

    logic [QP_W-1:0]                qprod;
    logic [bpcr_pkg::ADJ_W-1:0]     n_q;
    logic [bpcr_pkg::ADJ_W-1:0]     r6_q;
    logic                           r6_neg;

    logic [AW-1:0]              up_sum;
    logic [bpcr_pkg::POT_W-1:0] code_up;
    logic [bpcr_pkg::POT_W-1:0] code_dn;
    logic [bpcr_pkg::POT_W-1:0] code;

    assign prop_s  = {1'b0, i_gains.prop};
    assign deriv_s = {1'b0, i_gains.deriv};

    always_comb begin
        num = NUM_W'(r4_pprop) + NUM_W'(r4_pderiv);
        n_neg = num[NUM_W-1];
        num_abs = n_neg ? NUM_W'(-num) : NUM_W'(num);
        mag = num_abs[NUM_W-1:GAIN_FRAC_BITS];
        n_big = (EXT_W'(mag) >= LIMIT);
    end

    always_comb begin
        qprod = QP_W'(r5_m) * QP_W'(RECIP);
        n_q = r5_big ? Q_CAP : qprod[K +: bpcr_pkg::ADJ_W];
    end

    always_comb begin
        up_sum = AW'(r6_pot) + AW'(r6_q);
        code_up = (up_sum > AW'(bpcr_pkg::POT_MAX)) ? bpcr_pkg::POT_MAX
                                                   : up_sum[bpcr_pkg::POT_W-1:0];
        code_dn = (r6_q > bpcr_pkg::ADJ_W'(r6_pot)) ? '0
                                                     : r6_pot - bpcr_pkg::POT_W'(r6_q);
        code = r6_neg ? code_up : code_dn;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_ctl <= '0;
            r5_ctl <= '0;
            r6_ctl <= '0;
        end else begin
            r4_ctl <= i_ctl;
            r5_ctl <= r4_ctl;
            r6_ctl <= r5_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_pprop <= prop_s * i_err;
        r4_pderiv <= deriv_s * i_dsum;
        r4_sum <= i_sum;
        r4_prev <= i_prev;
        r4_pot <= i_pot;
        r4_pos <= i_pos;
        r5_neg <= n_neg;
        r5_big <= n_big;
        r5_m <= MW'(mag);
        r5_sum <= r4_sum;
        r5_prev <= r4_prev;
        r5_pot <= r4_pot;
        r5_pos <= r4_pos;
        r6_q <= n_q;
        r6_neg <= r5_neg;
        r6_sum <= r5_sum;
        r6_prev <= r5_prev;
        r6_pot <= r5_pot;
        r6_pos <= r5_pos;
    end

    assign o_done    = r6_ctl;
    assign o_wb_sum  = r6_sum;
    assign o_wb_prev = r6_prev;
    assign o_wb_pot  = r6_ctl.active ? code : '0;
    assign o_wb_pos  = r6_pos;

    assign o_result.ch     = r6_ctl.ch;
    assign o_result.enable = r6_ctl.active;
    assign o_result.pot    = r6_ctl.active ? code : '0;

endmodule

/* rtl/core/bpcr_out_fifo.sv */
module bpcr_out_fifo #(
    parameter int DEPTH = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  bpcr_pkg::t_result          i_data,
    output logic                       o_valid,
    input  logic                       i_stall,
    output bpcr_pkg::t_result          o_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    bpcr_pkg::t_result q_mem [DEPTH];

    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             pop;

    assign pop     = (r_count != '0) && !i_stall;
    assign o_valid = (r_count != '0);
    assign o_data  = q_mem[r_rd_ptr];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            q_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(pop);
        end
    end

endmodule

/* rtl/core/boxcar_pd_current_regulator_unit.sv */
// channel   direction  handshake            word
// input     in         i_valid / o_stall    i_channel, i_sense_sample, i_target_level
// result    out        o_valid / i_stall    o_out_channel, o_regulator_enable, o_pot_code
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// Words on different channels enter one per cycle while o_stall is low; one on the same
// channel waits until the previous one leaves the state-memory read to write-back loop.
// An accepted word passes the filter registers, the PD registers and the result queue.
// After reset, a clearing pass over all CHANNELS * 2**ceil(log2(WINDOW)) ring entries
// (2048 at defaults) zeroes sample ring and channel state; o_stall holds high meanwhile.
// Up to 8 results queue while the output stalls; input stalls when that credit runs out.
module boxcar_pd_current_regulator_unit #(
    parameter int WINDOW         = 512,
    parameter int CHANNELS       = 4,
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [bpcr_pkg::CH_W-1:0]           i_channel,
    input  logic [bpcr_pkg::SMP_W-1:0]          i_sense_sample,
    input  logic [bpcr_pkg::SMP_W-1:0]          i_target_level,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [bpcr_pkg::CH_W-1:0]           o_out_channel,
    output logic                                o_regulator_enable,
    output logic [bpcr_pkg::POT_W-1:0]          o_pot_code,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bpcr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bpcr_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int PW         = $clog2(WINDOW);
    localparam int SUM_W      = bpcr_pkg::SMP_W + PW;
    localparam int DIFF_W     = SUM_W + 1;
    localparam int FIFO_DEPTH = 8;
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int CH_CODES   = 1 << bpcr_pkg::CH_W;

    bpcr_pkg::t_gains                r_gains;
    logic [bpcr_pkg::THR_W-1:0]      r_low_thr;
    logic [CH_CODES-1:0]             r_busy, n_busy;
    logic [CNT_W-1:0]                r_inflight, n_inflight;

    logic                 clearing;
    logic                 credit_ok;
    logic                 accept;
    logic                 present;
    logic [CNT_W-1:0]     fifo_count;
    bpcr_pkg::t_item_ctl  in_ctl, f_ctl, done_ctl;
    bpcr_pkg::t_result    done_res, out_res;

    logic signed [DIFF_W-1:0]   f_err, f_dsum;
    logic [SUM_W-1:0]           f_sum, f_prev, wb_sum, wb_prev;
    logic [bpcr_pkg::POT_W-1:0] f_pot, wb_pot;
    logic [PW-1:0]              f_pos, wb_pos;

    assign credit_ok = ((CNT_W + 1)'(r_inflight) + (CNT_W + 1)'(fifo_count))
                       < (CNT_W + 1)'(FIFO_DEPTH);
    assign o_stall   = clearing || r_busy[i_channel] || !credit_ok;
    assign accept    = i_valid && !o_stall;
    assign present   = (int'(i_channel) < CHANNELS);

    assign in_ctl.valid   = accept;
    assign in_ctl.ch      = i_channel;
    assign in_ctl.present = present;
    assign in_ctl.active  = present && (i_target_level > r_low_thr);

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains.prop <= bpcr_pkg::PROP_GAIN_RST;
            r_gains.deriv <= bpcr_pkg::DERIV_GAIN_RST;
            r_low_thr <= bpcr_pkg::LOW_THR_RST;
        end else if (i_cfg_valid) begin
            unique case (bpcr_pkg::t_cfg_idx'(i_cfg_index))
                bpcr_pkg::CFG_PROP_GAIN: begin
                    r_gains.prop <= i_cfg_data;
                end
                bpcr_pkg::CFG_DERIV_GAIN: begin
                    r_gains.deriv <= i_cfg_data;
                end
                bpcr_pkg::CFG_LOW_THRESHOLD: begin
                    r_low_thr <= i_cfg_data[bpcr_pkg::THR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_busy = r_busy;
        if (done_ctl.valid) begin
            n_busy[done_ctl.ch] = 1'b0;
        end
        if (accept) begin
            n_busy[i_channel] = 1'b1;
        end
        n_inflight = r_inflight + CNT_W'(accept) - CNT_W'(done_ctl.valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= '0;
            r_inflight <= '0;
        end else begin
            r_busy <= n_busy;
            r_inflight <= n_inflight;
        end
    end

    bpcr_filter #(
        .WINDOW   (WINDOW),
        .CHANNELS (CHANNELS)
    ) u_filter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (in_ctl),
        .i_sample   (i_sense_sample),
        .i_level    (i_target_level),
        .i_wb_ctl   (done_ctl),
        .i_wb_sum   (wb_sum),
        .i_wb_prev  (wb_prev),
        .i_wb_pot   (wb_pot),
        .i_wb_pos   (wb_pos),
        .o_clearing (clearing),
        .o_ctl      (f_ctl),
        .o_err      (f_err),
        .o_dsum     (f_dsum),
        .o_sum      (f_sum),
        .o_prev     (f_prev),
        .o_pot      (f_pot),
        .o_pos      (f_pos)
    );

    bpcr_pd_calc #(
        .WINDOW         (WINDOW),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_pd_calc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_gains   (r_gains),
        .i_ctl     (f_ctl),
        .i_err     (f_err),
        .i_dsum    (f_dsum),
        .i_sum     (f_sum),
        .i_prev    (f_prev),
        .i_pot     (f_pot),
        .i_pos     (f_pos),
        .o_done    (done_ctl),
        .o_wb_sum  (wb_sum),
        .o_wb_prev (wb_prev),
        .o_wb_pot  (wb_pot),
        .o_wb_pos  (wb_pos),
        .o_result  (done_res)
    );

    bpcr_out_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (done_ctl.valid),
        .i_data  (done_res),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (out_res),
        .o_count (fifo_count)
    );

    assign o_out_channel      = out_res.ch;
    assign o_regulator_enable = out_res.enable;
    assign o_pot_code         = out_res.pot;

endmodule

/* rtl/core/bpcr_checker.sv */
module bpcr_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_stall,
    input logic                            o_valid,
    input logic                            i_stall,
    input logic [bpcr_pkg::CH_W-1:0]       o_out_channel,
    input logic                            o_regulator_enable,
    input logic [bpcr_pkg::POT_W-1:0]      o_pot_code
);

    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> o_stall)
        else $error("input taken before ring clearing pass");

    a_disabled_pot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_regulator_enable || (o_pot_code == '0)))
        else $error("disabled channel reports non-zero pot code");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_out_channel)
                                  && $stable(o_regulator_enable) && $stable(o_pot_code)))
        else $error("stalled result word changed");

endmodule

bind boxcar_pd_current_regulator_unit bpcr_checker u_bpcr_checker (.*);

/* test/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN          = 512;
    localparam int NCH          = 4;
    localparam int FRAC         = 16;
    localparam int NDIR         = 20;
    localparam int HOLD_CYCLES  = 200;
    localparam int IDLE_LIMIT   = 10000;
    localparam int DRAIN_CYCLES = 16;

    localparam longint PD_DIVISOR = longint'(WIN) * (longint'(1) << FRAC);

    localparam logic [bpcr_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

    typedef struct packed {
        logic [bpcr_pkg::CH_W-1:0]  ch;
        logic [bpcr_pkg::SMP_W-1:0] smp;
        logic [bpcr_pkg::SMP_W-1:0] tgt;
        logic                       typed;
        logic                       en;
        logic [bpcr_pkg::POT_W-1:0] pot;
    } t_dir_row;

    localparam t_dir_row DIR_ROWS [NDIR] = '{
        '{2'd0, 12'd4095, 12'd0,    1'b1, 1'b0, 8'd0},
        '{2'd1, 12'd0,    12'd149,  1'b1, 1'b0, 8'd0},
        '{2'd2, 12'd4095, 12'd4095, 1'b0, 1'b0, 8'd0},
        '{2'd3, 12'd0,    12'd150,  1'b0, 1'b0, 8'd0},
        '{2'd1, 12'd0,    12'd4095, 1'b0, 1'b0, 8'd0},
        '{2'd1, 12'd0,    12'd4095, 1'b0, 1'b0, 8'd0},
        '{2'd1, 12'd0,    12'd4095, 1'b0, 1'b0, 8'd0},
        '{2'd1, 12'd0,    12'd4095, 1'b0, 1'b0, 8'd0},
        '{2'd1, 12'd0,    12'd4095, 1'b0, 1'b0, 8'd0},
        '{2'd1, 12'd0,    12'd4095, 1'b0, 1'b0, 8'd0},
        '{2'd1, 12'd0,    12'd4095, 1'b0, 1'b0, 8'd0},
        '{2'd1, 12'd0,    12'd4095, 1'b1, 1'b1, 8'd255},
        '{2'd1, 12'd4095, 12'd0,    1'b1, 1'b0, 8'd0},
        '{2'd2, 12'd2048, 12'd2048, 1'b0, 1'b0, 8'd0},
        '{2'd3, 12'd4095, 12'd4095, 1'b0, 1'b0, 8'd0},
        '{2'd0, 12'd1,    12'd4094, 1'b0, 1'b0, 8'd0},
        '{2'd0, 12'd4094, 12'd1,    1'b1, 1'b0, 8'd0},
        '{2'd2, 12'd0,    12'd0,    1'b1, 1'b0, 8'd0},
        '{2'd3, 12'd2730, 12'd1365, 1'b0, 1'b0, 8'd0},
        '{2'd0, 12'd4095, 12'd4095, 1'b0, 1'b0, 8'd0}
    };

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_valid;
    logic                            o_stall;
    logic [bpcr_pkg::CH_W-1:0]       i_channel;
    logic [bpcr_pkg::SMP_W-1:0]      i_sense_sample;
    logic [bpcr_pkg::SMP_W-1:0]      i_target_level;
    logic                            o_valid;
    logic                            i_stall = 1'b0;
    logic [bpcr_pkg::CH_W-1:0]       o_out_channel;
    logic                            o_regulator_enable;
    logic [bpcr_pkg::POT_W-1:0]      o_pot_code;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [bpcr_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [bpcr_pkg::CFG_DATA_W-1:0] i_cfg_data;

    logic [bpcr_pkg::SMP_W-1:0]  ring [NCH][WIN];
    logic [20:0]                 win_sum [NCH];
    logic [20:0]                 prev_sum [NCH];
    logic [bpcr_pkg::POT_W-1:0]  pot_set [NCH];
    logic [8:0]                  ring_pos [NCH];
    logic [bpcr_pkg::GAIN_W-1:0] prop_gain;
    logic [bpcr_pkg::GAIN_W-1:0] deriv_gain;
    logic [bpcr_pkg::THR_W-1:0]  low_thr;

    bpcr_pkg::t_result pending_settings [$];

    int  error_count = 0;
    int  idle_cycles = 0;
    int  hold_asked  = 0;
    int  hold_done   = 0;
    int  rx_left     = 0;
    bit  quiet_phase = 1'b0;

    boxcar_pd_current_regulator_unit #(
        .WINDOW         (WIN),
        .CHANNELS       (NCH),
        .GAIN_FRAC_BITS (FRAC)
    ) u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_channel          (i_channel),
        .i_sense_sample     (i_sense_sample),
        .i_target_level     (i_target_level),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_out_channel      (o_out_channel),
        .o_regulator_enable (o_regulator_enable),
        .o_pot_code         (o_pot_code),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic bpcr_pkg::t_result regulate(input logic [bpcr_pkg::CH_W-1:0] ch,
                                                   input logic [bpcr_pkg::SMP_W-1:0] smp,
                                                   input logic [bpcr_pkg::SMP_W-1:0] tgt);
        bpcr_pkg::t_result res;
        logic [8:0]        pos;
        longint            s;
        longint            num;
        longint            adj;
        longint            code;
        res.ch     = ch;
        res.enable = 1'b0;
        res.pot    = '0;
        if (int'(ch) >= NCH) begin
            return res;
        end
        pos = ring_pos[ch];
        if (tgt > low_thr) begin
            win_sum[ch] = win_sum[ch] - 21'(ring[ch][pos]) + 21'(smp);
            ring[ch][pos] = smp;
            s = longint'(win_sum[ch]);
            num = longint'(prop_gain) * (s - longint'(tgt) * WIN)
                + longint'(deriv_gain) * (s - longint'(prev_sum[ch]));
            adj = num / PD_DIVISOR;
            prev_sum[ch] = win_sum[ch];
            code = longint'(pot_set[ch]) - adj;
            if (code > longint'(bpcr_pkg::POT_MAX)) begin
                code = longint'(bpcr_pkg::POT_MAX);
            end
            if (code < 0) begin
                code = 0;
            end
            pot_set[ch] = bpcr_pkg::POT_W'(code);
            res.enable  = 1'b1;
            res.pot     = pot_set[ch];
        end else begin
            pot_set[ch] = '0;
        end
        ring_pos[ch] = (int'(pos) == WIN - 1) ? 9'd0 : pos + 9'd1;
        return res;
    endfunction

    function automatic void apply_reg(input logic [bpcr_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [bpcr_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            bpcr_pkg::CFG_PROP_GAIN:     prop_gain  = data;
            bpcr_pkg::CFG_DERIV_GAIN:    deriv_gain = data;
            bpcr_pkg::CFG_LOW_THRESHOLD: low_thr    = data[bpcr_pkg::THR_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_phase || r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic write_reg(input logic [bpcr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bpcr_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg(idx, data);
    endtask

    task automatic send_word(input logic [bpcr_pkg::CH_W-1:0] ch,
                             input logic [bpcr_pkg::SMP_W-1:0] smp,
                             input logic [bpcr_pkg::SMP_W-1:0] tgt, input logic typed,
                             input bpcr_pkg::t_result typed_res);
        bpcr_pkg::t_result res;
        int                gap;
        i_valid        <= 1'b1;
        i_channel      <= ch;
        i_sense_sample <= smp;
        i_target_level <= tgt;
        do @(posedge i_clk); while (o_stall);
        res = regulate(ch, smp, tgt);
        if (typed) begin
            res = typed_res;
        end
        pending_settings.push_back(res);
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (pending_settings.size() != 0);
    endtask

    task automatic run_phase(input logic [bpcr_pkg::GAIN_W-1:0] prop,
                             input logic [bpcr_pkg::GAIN_W-1:0] deriv,
                             input logic [bpcr_pkg::CFG_DATA_W-1:0] thr_word,
                             input int items, input bit quiet, input bit pressure);
        int                         k;
        int                         v;
        logic [bpcr_pkg::CH_W-1:0]  ch;
        logic [bpcr_pkg::SMP_W-1:0] smp;
        logic [bpcr_pkg::SMP_W-1:0] tgt;
        i_valid <= 1'b0;
        wait_drained();
        write_reg(bpcr_pkg::CFG_PROP_GAIN, prop);
        write_reg(bpcr_pkg::CFG_DERIV_GAIN, deriv);
        write_reg(bpcr_pkg::CFG_LOW_THRESHOLD, thr_word);
        write_reg(CFG_SPARE_IDX, bpcr_pkg::CFG_DATA_W'($urandom));
        i_cfg_valid <= 1'b0;
        quiet_phase = quiet;
        if (pressure) begin
            hold_asked++;
        end
        for (k = 0; k < items; k++) begin
            ch = ($urandom_range(0, 9) < 8) ? 2'd0
                                             : bpcr_pkg::CH_W'($urandom_range(1, 3));
            if ($urandom_range(0, 99) < 85 && int'(low_thr) < 4095) begin
                tgt = bpcr_pkg::SMP_W'($urandom_range(int'(low_thr) + 1, 4095));
            end else begin
                tgt = bpcr_pkg::SMP_W'($urandom_range(0, 4095));
            end
            if ($urandom_range(0, 1) == 1) begin
                v = int'(tgt) + int'($urandom_range(0, 128)) - 64;
                v = (v < 0) ? 0 : (v > 4095) ? 4095 : v;
                smp = bpcr_pkg::SMP_W'(v);
            end else begin
                smp = bpcr_pkg::SMP_W'($urandom_range(0, 4095));
            end
            send_word(ch, smp, tgt, 1'b0, '0);
        end
        quiet_phase = 1'b0;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (rx_left > 0) begin
            rx_left--;
        end else if (hold_asked != hold_done) begin
            i_stall <= 1'b1;
            rx_left = HOLD_CYCLES - 1;
            hold_done++;
        end else if (quiet_phase) begin
            i_stall <= 1'b0;
        end else begin
            case ($urandom_range(0, 9)) inside
                [0:5]: begin
                    i_stall <= 1'b0;
                    rx_left = $urandom_range(0, 7);
                end
                [6:8]: begin
                    i_stall <= 1'b1;
                    rx_left = $urandom_range(0, 2);
                end
                default: begin
                    i_stall <= 1'b1;
                    rx_left = $urandom_range(9, 39);
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        bpcr_pkg::t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_settings.size() == 0) begin
                $display("%0t: result with no expectation, channel %0d enable %0d pot %0d",
                         $realtime, o_out_channel, o_regulator_enable, o_pot_code);
                error_count++;
            end else begin
                want = pending_settings.pop_front();
                check_field("out_channel", want.ch, o_out_channel);
                check_field("regulator_enable", want.enable, o_regulator_enable);
                check_field("pot_code", want.pot, o_pot_code);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $realtime, IDLE_LIMIT);
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int c;
        int k;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_channel      = '0;
        i_sense_sample = '0;
        i_target_level = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        for (c = 0; c < NCH; c++) begin
            for (k = 0; k < WIN; k++) begin
                ring[c][k] = '0;
            end
            win_sum[c]  = '0;
            prev_sum[c] = '0;
            pot_set[c]  = '0;
            ring_pos[c] = '0;
        end
        prop_gain  = bpcr_pkg::PROP_GAIN_RST;
        deriv_gain = bpcr_pkg::DERIV_GAIN_RST;
        low_thr    = bpcr_pkg::LOW_THR_RST;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < NDIR; k++) begin
            send_word(DIR_ROWS[k].ch, DIR_ROWS[k].smp, DIR_ROWS[k].tgt, DIR_ROWS[k].typed,
                      '{ch: DIR_ROWS[k].ch, enable: DIR_ROWS[k].en, pot: DIR_ROWS[k].pot});
        end

        run_phase(16'hFFFF, 16'hFFFF, 16'hF000, 200, 1'b1, 1'b0);
        run_phase(16'h0000, 16'h0000, 16'hFFFF, 30, 1'b0, 1'b0);
        run_phase(bpcr_pkg::GAIN_W'($urandom), bpcr_pkg::GAIN_W'($urandom),
                  {4'($urandom), bpcr_pkg::THR_W'($urandom_range(0, 1023))},
                  250, 1'b0, 1'b1);
        run_phase(bpcr_pkg::GAIN_W'($urandom), 16'h0000, {4'($urandom), 12'd149},
                  170, 1'b0, 1'b0);

        i_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
